>>> sv/osg_pkg.sv
package osg_pkg;

  // Beams at or above this angle index take no part in the nearest range
  localparam int MaxBeams = 128;
  localparam logic [8:0] MAX_BEAMS_W = 9'(MaxBeams);

  // Angles are held in units of 2^-15 degree
  localparam logic [22:0] HALF_TURN = 23'd5898240;      // 180 degrees
  localparam logic [45:0] BHASKARA_K = 46'd40500 << 30;
  localparam logic [32:0] ROUND_HALF = 33'd32768;

  localparam logic signed [17:0] LIM_MAX = 18'sd32767;
  localparam logic signed [17:0] LIM_MIN = -18'sd32768;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_LATERAL = 3'd0;
  localparam logic [2:0] CFG_DEFAULT = 3'd1;
  localparam logic [2:0] CFG_SLOPE   = 3'd2;
  localparam logic [2:0] CFG_OFFSET  = 3'd3;
  localparam logic [2:0] CFG_MARGIN  = 3'd4;

  // Brake and throttle levels, percent
  localparam logic [6:0] BRAKE_HARD  = 7'd50;
  localparam logic [6:0] BRAKE_MID   = 7'd30;
  localparam logic [6:0] BRAKE_LIGHT = 7'd15;
  localparam logic [6:0] BRAKE_NONE  = 7'd0;
  localparam logic [6:0] THR_NONE    = 7'd0;
  localparam logic [6:0] THR_LOW     = 7'd10;
  localparam logic [6:0] THR_HIGH    = 7'd20;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_P    = 4'd2;
  localparam logic [3:0] OP_L0   = 4'd3;
  localparam logic [3:0] OP_L1   = 4'd4;
  localparam logic [3:0] OP_R0   = 4'd5;
  localparam logic [3:0] OP_R1   = 4'd6;
  localparam logic [3:0] OP_R2   = 4'd7;
  localparam logic [3:0] OP_CMP  = 4'd8;
  localparam logic [3:0] OP_LIM  = 4'd9;
  localparam logic [3:0] OP_DEC  = 4'd10;
  localparam logic [3:0] OP_OUT  = 4'd11;

  typedef struct packed {
    logic [15:0] lateral_limit_mm;
    logic [14:0] default_limit_mm_s;
    logic [15:0] slope_q16;
    logic [14:0] offset_mm_s;
    logic [14:0] over_margin_mm_s;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage

>>> sv/osg_ctrl.sv
module osg_ctrl import osg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P    = 4'd1;
  localparam logic [3:0] S_L0   = 4'd2;
  localparam logic [3:0] S_L1   = 4'd3;
  localparam logic [3:0] S_R0   = 4'd4;
  localparam logic [3:0] S_R1   = 4'd5;
  localparam logic [3:0] S_R2   = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_LIM  = 4'd8;
  localparam logic [3:0] S_DEC  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.op = OP_LOAD;
          state_next = S_P;
        end
      end
      S_P:   begin cmd.op = OP_P;  state_next = S_L0; end
      S_L0:  begin cmd.op = OP_L0; state_next = S_L1; end
      S_L1:  begin cmd.op = OP_L1; state_next = S_R0; end
      S_R0:  begin cmd.op = OP_R0; state_next = S_R1; end
      S_R1:  begin cmd.op = OP_R1; state_next = S_R2; end
      S_R2:  begin cmd.op = OP_R2; state_next = S_CMP; end
      S_CMP: begin
        cmd.op = OP_CMP;
        state_next = status.last ? S_LIM : S_IDLE;
      end
      S_LIM: begin cmd.op = OP_LIM; state_next = S_DEC; end
      S_DEC: begin cmd.op = OP_DEC; state_next = S_OUT; end
      S_OUT: begin
        // hold here until the output register can take the decision
        if (status.out_free) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/osg_dp.sv
module osg_dp import osg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [15:0] nearest_so_far,
  output logic        hit_flag
);

  logic [15:0] range_r;
  logic [6:0]  beam_r;
  logic        last_r;
  logic [15:0] speed_r;
  logic [21:0] d_r;
  logic [42:0] p_r;
  logic [45:0] q_r;
  logic [58:0] lhs_r;
  logic [61:0] rhs_r;
  logic [44:0] prod_r;
  logic signed [15:0] lim_r;
  logic [47:0] out_data;
  logic        out_valid;

  logic [15:0] u;
  logic [21:0] centre, bpos, d_in;
  logic [21:0] mul_a;
  logic [22:0] mul_b;
  logic        in_corr;
  logic [32:0] rnd;
  logic signed [17:0] lim_raw, lim_w, v18, v2, thr;
  logic [6:0]  brake, thr_pct;

  // Heading: 50 * (steering + 32768), steering offset to unsigned
  assign u = {~s_tdata[38], s_tdata[37:23]};
  assign centre = ({6'b0, u} << 5) + ({6'b0, u} << 4) + ({6'b0, u} << 1);
  assign bpos = {s_tdata[22:16], 15'b0};
  assign d_in = (bpos >= centre) ? (bpos - centre) : (centre - bpos);

  // One shared multiplier, operands picked by the step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_P:  begin mul_a = d_r;                mul_b = HALF_TURN - {1'b0, d_r}; end
      OP_L0: begin mul_a = {6'b0, range_r};    mul_b = {1'b0, prod_r[21:0]}; end
      OP_L1: begin mul_a = {6'b0, range_r};    mul_b = {2'b0, p_r[42:22]}; end
      OP_R0: begin mul_a = {6'b0, cfg.lateral_limit_mm}; mul_b = q_r[22:0]; end
      OP_R1: begin mul_a = {6'b0, cfg.lateral_limit_mm}; mul_b = q_r[45:23]; end
      OP_LIM: begin mul_a = {6'b0, nearest_so_far}; mul_b = {7'b0, cfg.slope_q16}; end
      default: ;
    endcase
  end

  assign in_corr = ({2'b0, beam_r} < MAX_BEAMS_W) && ({1'b0, lhs_r, 2'b0} <= rhs_r);

  // Limit from nearest range: product rounded half up, less offset, saturated; the configured default without a hit
  assign rnd = {1'b0, prod_r[31:0]} + ROUND_HALF;
  assign lim_raw = $signed({1'b0, rnd[32:16]}) - $signed({3'b0, cfg.offset_mm_s});
  always_comb begin
    if (!hit_flag) lim_w = $signed({3'b0, cfg.default_limit_mm_s});
    else if (lim_raw > LIM_MAX) lim_w = LIM_MAX;
    else if (lim_raw < LIM_MIN) lim_w = LIM_MIN;
    else lim_w = lim_raw;
  end

  assign v18 = $signed({{2{speed_r[15]}}, speed_r});
  assign v2  = $signed({speed_r[15], speed_r, 1'b0});
  assign thr = $signed({{2{lim_r[15]}}, lim_r}) + $signed({3'b0, cfg.over_margin_mm_s});

  always_comb begin
    if (v18 >= thr) begin
      brake = BRAKE_HARD;  thr_pct = THR_NONE;
    end else if (v2 <= $signed({{2{lim_r[15]}}, lim_r})) begin
      brake = BRAKE_NONE;  thr_pct = THR_HIGH;
    end else if (v18 >= $signed({{2{lim_r[15]}}, lim_r})) begin
      brake = BRAKE_MID;   thr_pct = THR_LOW;
    end else begin
      brake = BRAKE_LIGHT; thr_pct = THR_HIGH;
    end
  end

  assign status.last = last_r;
  assign status.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    prod_r <= 45'(mul_a) * 45'(mul_b);
    case (cmd.op)
      OP_LOAD: begin
        range_r <= s_tdata[15:0];
        beam_r  <= s_tdata[22:16];
        last_r  <= s_tlast;
        speed_r <= s_tdata[54:39];
        d_r     <= d_in;
      end
      OP_L0: p_r <= prod_r[42:0];
      OP_L1: begin
        lhs_r <= {21'b0, prod_r[37:0]};
        q_r   <= BHASKARA_K - {3'b0, p_r};
      end
      OP_R0: lhs_r <= lhs_r + {prod_r[36:0], 22'b0};
      OP_R1: rhs_r <= {23'b0, prod_r[38:0]};
      OP_R2: rhs_r <= rhs_r + {prod_r[38:0], 23'b0};
      OP_DEC: lim_r <= lim_w[15:0];
      OP_OUT: out_data <= {1'b0, hit_flag, nearest_so_far, lim_r, thr_pct, brake};
      default: ;
    endcase
  end

  // Scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_so_far <= 16'hFFFF;
      hit_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CMP && in_corr) begin
        hit_flag <= 1'b1;
        if (range_r < nearest_so_far) nearest_so_far <= range_r;
      end
      if (cmd.op == OP_OUT) begin
        nearest_so_far <= 16'hFFFF;
        hit_flag <= 1'b0;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

endmodule

>>> sv/obstacle_speed_governor_top.sv
// Obstacle speed governor.
// Input stream (s_*): one laser beam per transfer; s_tlast marks the final beam
// of a scan. Each beam is tested against a corridor around the steering heading
// and the nearest range inside it is kept.
// Output stream (m_*): one transfer per scan, issued after the beam with
// s_tlast, carrying the brake and throttle levels, the speed limit used, the
// nearest corridor range and whether any beam hit.
// Flow: s_tready is high only while idle, so each beam is taken after the last
// one is through its steps; a last beam adds the LIM, DEC and OUT steps before
// m_tvalid rises. Five products per beam go through one shared 22x23 multiplier.
// Configuration: cfg_we writes cfg_data to register cfg_index; indexes beyond
// the register list are ignored. Write only while no scan is in progress.
// Reset: rst (synchronous) restores the register defaults, clears the scan
// state, holds s_tready low and drops m_tvalid.
// Stall: a result waits in the output register while m_tready is low; the
// next scan's beams are still taken and only the following decision waits.
module obstacle_speed_governor_top import osg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // range_mm, beam_index, steering, vehicle_speed
  input  logic        s_tlast,   // last_beam
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // brake_pct, throttle_pct, speed_limit,
                                 // nearest_range, obstacle_seen
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic [15:0] nearest_so_far;
  logic        hit_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lateral_limit_mm   <= 16'd2500;
      cfg.default_limit_mm_s <= 15'd6000;
      cfg.slope_q16          <= 16'd22479;
      cfg.offset_mm_s        <= 15'd857;
      cfg.over_margin_mm_s   <= 15'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LATERAL: cfg.lateral_limit_mm   <= cfg_data;
        CFG_DEFAULT: cfg.default_limit_mm_s <= cfg_data[14:0];
        CFG_SLOPE:   cfg.slope_q16          <= cfg_data;
        CFG_OFFSET:  cfg.offset_mm_s        <= cfg_data[14:0];
        CFG_MARGIN:  cfg.over_margin_mm_s   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  osg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  osg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .nearest_so_far (nearest_so_far),
    .hit_flag       (hit_flag)
  );

  // No hit in the scan means the nearest range reads as all ones
  a_no_hit_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[46]) |-> (m_tdata[45:30] == 16'hFFFF))
    else $error("nearest range set without a corridor hit");

  // Without a hit the limit is the configured default
  a_no_hit_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[46]) |-> (m_tdata[29:14] == {1'b0, cfg.default_limit_mm_s}))
    else $error("default speed limit not used");

  // Brake and throttle only ever come in the four decided pairs
  a_level_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[6:0] == BRAKE_HARD && m_tdata[13:7] == THR_NONE) ||
                  (m_tdata[6:0] == BRAKE_NONE && m_tdata[13:7] == THR_HIGH) ||
                  (m_tdata[6:0] == BRAKE_MID && m_tdata[13:7] == THR_LOW) ||
                  (m_tdata[6:0] == BRAKE_LIGHT && m_tdata[13:7] == THR_HIGH)))
    else $error("illegal brake and throttle pair");

  // Scan state is cleared in the cycle the decision is registered
  a_scan_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |=> (!hit_flag && nearest_so_far == 16'hFFFF))
    else $error("scan state not cleared after decision");

endmodule

>>> tb/tb_obstacle_speed_governor_top.sv
`timescale 1ns / 100ps

module tb_obstacle_speed_governor_top;
  import osg_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_BEAMS  = 1880;

  // angles in units of 2^-15 degree; heading = 50 * (steering + 1) degrees
  localparam longint DEG_UNITS    = 32768;
  localparam longint CENTRE_SCALE = 50;
  localparam logic [15:0] NO_RANGE = 16'hFFFF;

  localparam cfg_t CFG_AT_RESET = '{16'd2500, 15'd6000, 16'd22479, 15'd857, 15'd1000};

  typedef struct packed {
    logic [6:0]  brake;
    logic [6:0]  throttle;
    logic [15:0] limit;
    logic [15:0] nearest;
    logic        seen;
  } decision_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // range_mm, beam_index, steering, vehicle_speed
  logic        s_tlast;   // last_beam
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // brake_pct, throttle_pct, speed_limit, nearest_range,
                          // obstacle_seen
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // governor model state
  cfg_t        gov_cfg;
  logic [15:0] nearest_mm;
  bit          scan_hit;
  decision_t   decisions_due[$];

  int unsigned cycle_count = 0;
  int unsigned fault_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned beam_count = 0;
  int unsigned scan_count = 0;
  int unsigned hit_scan_count = 0;
  int unsigned cfg_write_count = 0;
  int unsigned n_hard = 0, n_mid = 0, n_light = 0, n_go = 0;
  int unsigned rx_hold = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  obstacle_speed_governor_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding", cycle_count,
               decisions_due.size());
      $display("tb_obstacle_speed_governor_top: FAIL");
      $finish;
    end
  end

  // result side back-pressure: hold ready low while rx_hold counts down on valid
  always @(negedge clk) begin
    m_tready <= (rx_hold == 0);
    if (rx_hold != 0 && m_tvalid === 1'b1) rx_hold--;
  end

  always @(posedge clk) begin : check_results
    decision_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[6:0], m_tdata[13:7], m_tdata[29:14], m_tdata[45:30], m_tdata[46]};
      if (decisions_due.size() == 0) begin
        fault_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result transfer %h", $time, m_tdata);
      end else begin
        want = decisions_due.pop_front();
        if (got.brake !== want.brake || got.throttle !== want.throttle ||
            got.limit !== want.limit || got.nearest !== want.nearest ||
            got.seen !== want.seen) begin
          fault_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $write("%0t: mismatch (exp/act) brake %0d/%0d throttle %0d/%0d ", $time,
                   want.brake, got.brake, want.throttle, got.throttle);
            $display("limit %0d/%0d nearest %0d/%0d seen %0d/%0d",
                     $signed(want.limit), $signed(got.limit), want.nearest,
                     got.nearest, want.seen, got.seen);
          end
        end
      end
      rx_hold = rx_steady ? 0 : $urandom_range(0, 4);
    end
  end

  function automatic longint limit_for(logic [15:0] closest, bit hit);
    longint lim;
    if (!hit) return longint'(gov_cfg.default_limit_mm_s);
    // product rounded half up to whole mm/s, then offset, then saturated
    lim = longint'((64'(closest) * 64'(gov_cfg.slope_q16) + 64'(ROUND_HALF)) >> 16)
          - longint'(gov_cfg.offset_mm_s);
    if (lim > longint'(LIM_MAX)) lim = longint'(LIM_MAX);
    if (lim < longint'(LIM_MIN)) lim = longint'(LIM_MIN);
    return lim;
  endfunction

  task automatic send_beam(input logic [15:0] rng, input logic [6:0] beam, input bit last,
                           input logic [15:0] steer, input logic [15:0] speed);
    int gap;
    longint centre, offs, lim, v;
    longint unsigned d, p;
    decision_t due;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, speed, steer, beam, rng};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    beam_count++;

    // lateral offset test with sin = 4p / (40500 - p), cross-multiplied so it stays exact
    centre = CENTRE_SCALE * longint'($signed(steer)) + CENTRE_SCALE * DEG_UNITS;
    offs = longint'(beam) * DEG_UNITS - centre;
    d = (offs < 0) ? -offs : offs;
    p = d * (64'(HALF_TURN) - d);
    if (int'(beam) < MaxBeams &&
        64'(rng) * 4 * p <= 64'(gov_cfg.lateral_limit_mm) * (64'(BHASKARA_K) - p)) begin
      scan_hit = 1'b1;
      if (rng < nearest_mm) nearest_mm = rng;
    end

    if (last) begin
      lim = limit_for(nearest_mm, scan_hit);
      v = longint'($signed(speed));
      due.limit   = 16'(lim);
      due.nearest = nearest_mm;
      due.seen    = scan_hit;
      if (v >= lim + longint'(gov_cfg.over_margin_mm_s)) begin
        due.brake = BRAKE_HARD;
        due.throttle = THR_NONE;
        n_hard++;
      end else if (2 * v <= lim) begin
        due.brake = BRAKE_NONE;
        due.throttle = THR_HIGH;
        n_go++;
      end else if (v >= lim) begin
        due.brake = BRAKE_MID;
        due.throttle = THR_LOW;
        n_mid++;
      end else begin
        due.brake = BRAKE_LIGHT;
        due.throttle = THR_HIGH;
        n_light++;
      end
      decisions_due = {decisions_due, due};
      scan_count++;
      if (scan_hit) hit_scan_count++;
      nearest_mm = NO_RANGE;
      scan_hit = 1'b0;
    end
    @(negedge clk);
  endtask

  // stop sending and let every pending decision come out
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (decisions_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_LATERAL: gov_cfg.lateral_limit_mm   = val;
      CFG_DEFAULT: gov_cfg.default_limit_mm_s = val[14:0];
      CFG_SLOPE:   gov_cfg.slope_q16          = val;
      CFG_OFFSET:  gov_cfg.offset_mm_s        = val[14:0];
      CFG_MARGIN:  gov_cfg.over_margin_mm_s   = val[14:0];
      default: ;
    endcase
    cfg_write_count++;
  endtask

  task automatic test_reset_defaults();
    // zero range straight ahead, then a full-scale range that still counts as a hit
    send_beam(16'd0, 7'd50, 1'b1, 16'h0000, 16'h0000);
    send_beam(NO_RANGE, 7'd50, 1'b1, 16'h0000, 16'h7FFF);
    // scan with nothing in the corridor: default limit applies
    send_beam(NO_RANGE, 7'd127, 1'b0, 16'h8000, 16'h0000);
    send_beam(16'd40000, 7'd0, 1'b1, 16'h7FFF, 16'd7000);
    // the no-brake, mid and light decision levels against the default limit
    send_beam(16'd60000, 7'd0, 1'b1, 16'h7FFF, 16'd3000);
    send_beam(16'd60000, 7'd0, 1'b1, 16'h7FFF, 16'd6000);
    send_beam(16'd60000, 7'd0, 1'b1, 16'h7FFF, 16'd4000);
    send_beam(16'd60000, 7'd0, 1'b1, 16'h7FFF, 16'h8000);
    // several beams: nearest one in the corridor wins, wide angle but short range counts
    send_beam(16'd20000, 7'd48, 1'b0, 16'h0000, 16'h0000);
    send_beam(16'd9000, 7'd50, 1'b0, 16'h0000, 16'h0000);
    send_beam(16'd5000, 7'd10, 1'b0, 16'h0000, 16'h0000);
    send_beam(16'd100, 7'd90, 1'b0, 16'h0000, 16'h0000);
    send_beam(16'd30000, 7'd51, 1'b1, 16'h0000, 16'd1000);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_LATERAL, 16'hFFFF);
    write_reg(CFG_DEFAULT, 16'hFFFF);
    write_reg(CFG_SLOPE, 16'hFFFF);
    write_reg(CFG_OFFSET, 16'h0000);
    write_reg(CFG_MARGIN, 16'h0000);
    // limit saturates high
    send_beam(NO_RANGE, 7'd50, 1'b1, 16'h0000, 16'h7FFF);
    send_beam(16'd1234, 7'd0, 1'b1, 16'h8000, 16'h8000);
    wait_drain();

    write_reg(CFG_LATERAL, 16'h0000);
    write_reg(CFG_DEFAULT, 16'h0000);
    write_reg(CFG_SLOPE, 16'h0000);
    write_reg(CFG_OFFSET, 16'hFFFF);
    write_reg(CFG_MARGIN, 16'hFFFF);
    // zero corridor: only zero range or zero angle difference get in
    send_beam(16'd0, 7'd20, 1'b1, 16'h0000, 16'h8000);
    send_beam(16'd5, 7'd50, 1'b0, 16'h0000, 16'h0000);
    send_beam(16'd1000, 7'd0, 1'b1, 16'h7FFF, 16'h0000);
    send_beam(16'd1, 7'd10, 1'b1, 16'h0000, 16'h0000);
    wait_drain();

    write_reg(CFG_LATERAL, CFG_AT_RESET.lateral_limit_mm);
    write_reg(CFG_DEFAULT, 16'(CFG_AT_RESET.default_limit_mm_s));
    write_reg(CFG_SLOPE, CFG_AT_RESET.slope_q16);
    write_reg(CFG_OFFSET, 16'(CFG_AT_RESET.offset_mm_s));
    write_reg(CFG_MARGIN, 16'(CFG_AT_RESET.over_margin_mm_s));
  endtask

  task automatic test_random_scans();
    int unsigned start;
    int n_beams, aim;
    bit wobble, last;
    logic [15:0] steer, rng, speed, val;
    logic [6:0] beam;
    longint lim, v, span;
    start = beam_count;
    while (beam_count - start < RANDOM_BEAMS) begin
      for (int idx = 0; idx <= int'(CFG_MARGIN); idx++) begin
        case ($urandom_range(0, 4))
          0: val = 16'h0000;
          1: val = 16'hFFFF;
          default: val = 16'($urandom);
        endcase
        write_reg(3'(idx), val);
      end
      // indexes past the register list must leave the settings alone
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(int'(CFG_MARGIN) + 1, 7)), 16'($urandom));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);

      repeat ($urandom_range(4, 10)) begin
        n_beams = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        steer = 16'($urandom);
        wobble = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_beams; i++) begin
          last = (i == n_beams - 1);
          if (wobble) steer = 16'($urandom);
          // mostly aim near the heading so that corridor hits are common
          if ($urandom_range(0, 3) == 0) begin
            beam = 7'($urandom);
          end else begin
            aim = int'((CENTRE_SCALE * (longint'($signed(steer)) + DEG_UNITS)) / DEG_UNITS);
            aim = aim + int'($urandom_range(0, 8)) - 4;
            if (aim < 0) aim = 0;
            beam = 7'(aim);
          end
          case ($urandom_range(0, 5))
            0: rng = 16'($urandom);
            1: rng = NO_RANGE;
            2: rng = 16'd0;
            default: rng = 16'($urandom_range(0, 6000));
          endcase
          speed = 16'($urandom);
          if (last && $urandom_range(0, 3) != 0) begin
            // speed spread around the limit so every decision level turns up
            lim = limit_for(nearest_mm, scan_hit);
            span = ((lim < 0) ? -lim : lim) + longint'(gov_cfg.over_margin_mm_s) + 200;
            v = lim / 2 - 100 + longint'($urandom_range(0, int'(span) + 100));
            if (v > longint'(LIM_MAX)) v = longint'(LIM_MAX);
            if (v < longint'(LIM_MIN)) v = longint'(LIM_MIN);
            speed = 16'(v);
          end
          send_beam(rng, beam, last, steer, speed);
        end
        if ($urandom_range(0, 15) == 0) wait_drain();
      end
      wait_drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_LATERAL;
    cfg_data  = '0;
    gov_cfg    = CFG_AT_RESET;
    nearest_mm = NO_RANGE;
    scan_hit   = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_scans();

    wait_drain();
    fault_count += decisions_due.size();

    $display("covered %0d beams in %0d scans, %0d with a corridor hit, %0d register writes",
             beam_count, scan_count, hit_scan_count, cfg_write_count);
    $display("decisions: hard brake %0d, mid %0d, light %0d, throttle only %0d; %0d mismatches",
             n_hard, n_mid, n_light, n_go, mismatch_count);
    if (fault_count == 0)
      $display("tb_obstacle_speed_governor_top: PASS");
    else
      $display("tb_obstacle_speed_governor_top: FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/osg_pkg.sv
sv/osg_ctrl.sv
sv/osg_dp.sv
sv/obstacle_speed_governor_top.sv
tb/tb_obstacle_speed_governor_top.sv
